// ===== rtl/esma_pkg.sv =====
package esma_pkg;

	localparam int WINDOW_LENGTH = 10;
	localparam int SLOT_W = $clog2(WINDOW_LENGTH);
	localparam int COUNT_W = 16;
	localparam int SPEED_W = 32;
	localparam int SCALE_W = 32;
	localparam int FRAC_W = 16;
	localparam int PROD_W = COUNT_W + SCALE_W;
	localparam int TOTAL_W = SPEED_W + SLOT_W;

	localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

	// reciprocal of the window length, exact for any total magnitude
	localparam int RECIP_SHIFT = TOTAL_W + SLOT_W;
	localparam int RECIP_W = TOTAL_W + 1;
	localparam logic [63:0] RECIP_FULL =
		((64'd1 << RECIP_SHIFT) + 64'(WINDOW_LENGTH) - 64'd1) / 64'(WINDOW_LENGTH);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

	// split points for the partial products
	localparam int LO_W = (TOTAL_W + 1) / 2;
	localparam int HI_W = TOTAL_W - LO_W;
	localparam int RHI_W = RECIP_W - LO_W;
	localparam int SUM_W = TOTAL_W + RECIP_W;

	typedef struct packed {
		logic              accept;
		logic              adv;
		logic              upd;
		logic [SLOT_W-1:0] slot;
	} esma_ctrl_t;

endpackage

// ===== rtl/esma_if.sv =====
interface esma_sample_if;
	logic        valid;
	logic        ready;
	logic [15:0] left_count;
	logic [15:0] right_count;

	modport source (output valid, left_count, right_count, input ready);
	modport sink (input valid, left_count, right_count, output ready);
endinterface

interface esma_speed_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] left_speed;
	logic signed [31:0] right_speed;
	logic signed [31:0] left_speed_average;
	logic signed [31:0] right_speed_average;

	modport source (output valid, left_speed, right_speed, left_speed_average,
		right_speed_average, input ready);
	modport sink (input valid, left_speed, right_speed, left_speed_average,
		right_speed_average, output ready);
endinterface

// ===== rtl/esma_wheel.sv =====
module esma_wheel import esma_pkg::*; (
	input  logic                      clk,
	input  logic                      arst_n,
	input  esma_ctrl_t                ctrl,
	input  logic [SCALE_W-1:0]        scale,
	input  logic [COUNT_W-1:0]        count,
	output logic signed [SPEED_W-1:0] speed,
	output logic signed [SPEED_W-1:0] speed_average
);

	logic [COUNT_W-1:0]        prev_q;
	logic signed [COUNT_W-1:0] delta_s1;
	logic signed [PROD_W-1:0]  prod_s2;
	logic signed [PROD_W:0]    prod_full;
	logic signed [SPEED_W-1:0] speed_c;
	logic signed [SPEED_W-1:0] win_q [WINDOW_LENGTH];
	logic signed [TOTAL_W-1:0] total_q;
	logic signed [TOTAL_W-1:0] total_nxt;
	logic signed [SPEED_W-1:0] speed_s3;
	logic signed [TOTAL_W-1:0] total_s3;
	logic [TOTAL_W-1:0]        mag;
	logic [LO_W+LO_W-1:0]      pp_ll_s4;
	logic [LO_W+RHI_W-1:0]     pp_lh_s4;
	logic [HI_W+LO_W-1:0]      pp_hl_s4;
	logic [HI_W+RHI_W-1:0]     pp_hh_s4;
	logic                      neg_s4;
	logic signed [SPEED_W-1:0] speed_s4;
	logic [SUM_W-1:0]          sum;
	logic [TOTAL_W-1:0]        quo;
	logic [TOTAL_W-1:0]        avg;
	logic signed [SPEED_W-1:0] speed_s5;
	logic signed [SPEED_W-1:0] avg_s5;

	// previous count advances with every accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (ctrl.accept) begin
			prev_q <= count;
		end
	end

	assign prod_full = delta_s1 * $signed({1'b0, scale});
	assign speed_c = prod_s2[PROD_W-1:FRAC_W];
	assign total_nxt = total_q + {{SLOT_W{speed_c[SPEED_W-1]}}, speed_c}
		- {{SLOT_W{win_q[ctrl.slot][SPEED_W-1]}}, win_q[ctrl.slot]};

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			delta_s1 <= count - prev_q;
			prod_s2  <= prod_full[PROD_W-1:0];
			speed_s3 <= speed_c;
			total_s3 <= total_nxt;
		end
	end

	// sliding window and running total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_LENGTH; i++) begin
				win_q[i] <= '0;
			end
			total_q <= '0;
		end else if (ctrl.upd) begin
			win_q[ctrl.slot] <= speed_c;
			total_q <= total_nxt;
		end
	end

	// divide by the window length: reciprocal multiply in four pieces
	assign mag = total_s3[TOTAL_W-1] ? (~total_s3 + 1'b1) : total_s3;

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			pp_ll_s4 <= mag[LO_W-1:0] * RECIP[LO_W-1:0];
			pp_lh_s4 <= mag[LO_W-1:0] * RECIP[RECIP_W-1:LO_W];
			pp_hl_s4 <= mag[TOTAL_W-1:LO_W] * RECIP[LO_W-1:0];
			pp_hh_s4 <= mag[TOTAL_W-1:LO_W] * RECIP[RECIP_W-1:LO_W];
			neg_s4   <= total_s3[TOTAL_W-1];
			speed_s4 <= speed_s3;
		end
	end

	assign sum = SUM_W'(pp_ll_s4)
		+ ((SUM_W'(pp_lh_s4) + SUM_W'(pp_hl_s4)) << LO_W)
		+ (SUM_W'(pp_hh_s4) << (2 * LO_W));
	assign quo = TOTAL_W'(sum >> RECIP_SHIFT);
	assign avg = neg_s4 ? (~quo + 1'b1) : quo;

	always_ff @(posedge clk) begin
		if (ctrl.adv) begin
			speed_s5 <= speed_s4;
			avg_s5   <= avg[SPEED_W-1:0];
		end
	end

	assign speed = speed_s5;
	assign speed_average = avg_s5;

endmodule

// ===== rtl/encoder_speed_moving_average.sv =====
// stages s1 to s5 carry an accepted sample transaction to its speed transaction
// throughput: one transaction per cycle; the five stages advance together and
//   hold while the output transaction waits
// reset: previous counts, windows and running totals clear to zero, scale to 1.0
module encoder_speed_moving_average import esma_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	esma_sample_if.sink        samples,
	esma_speed_if.source       speeds,
	input  logic               scale_we,
	input  logic [SCALE_W-1:0] scale_wdata
);

	logic [SCALE_W-1:0] scale_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               valid_s1;
	logic               valid_s2;
	logic               valid_s3;
	logic               valid_s4;
	logic               valid_s5;
	esma_ctrl_t         ctrl;

	assign ctrl.adv = !valid_s5 || speeds.ready;
	assign ctrl.accept = samples.valid && ctrl.adv;
	assign ctrl.upd = valid_s2 && ctrl.adv;
	assign ctrl.slot = slot_q;

	assign samples.ready = ctrl.adv;
	assign speeds.valid = valid_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
		end else if (scale_we) begin
			scale_q <= scale_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (ctrl.adv) begin
			valid_s1 <= samples.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4;
		end
	end

	// window write position shared by both wheels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (ctrl.upd) begin
			if (slot_q == SLOT_W'(WINDOW_LENGTH - 1)) begin
				slot_q <= '0;
			end else begin
				slot_q <= slot_q + 1'b1;
			end
		end
	end

	esma_wheel u_left (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.scale         (scale_q),
		.count         (samples.left_count),
		.speed         (speeds.left_speed),
		.speed_average (speeds.left_speed_average)
	);

	esma_wheel u_right (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.scale         (scale_q),
		.count         (samples.right_count),
		.speed         (speeds.right_speed),
		.speed_average (speeds.right_speed_average)
	);

endmodule

// ===== tb/encoder_speed_moving_average_tb.sv =====
module encoder_speed_moving_average_tb;
	import esma_pkg::*;

	localparam int TICKS_PER_PHASE = 191;
	localparam int PHASES = 8;
	localparam int LONG_HOLD_CYCLES = 300;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PRINT_LIMIT = 100;
	localparam longint SPEED_MAX = 64'sd2147483647;
	localparam longint SPEED_MIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [31:0] left_speed;
		logic signed [31:0] right_speed;
		logic signed [31:0] left_speed_average;
		logic signed [31:0] right_speed_average;
	} speed_result_t;

	typedef struct {
		logic          set_scale;
		logic [31:0]   scale;
		logic [15:0]   left_count;
		logic [15:0]   right_count;
		logic          typed;
		speed_result_t result;
	} tick_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic scale_we;
	logic [SCALE_W-1:0] scale_wdata;

	esma_sample_if samples_if();
	esma_speed_if speeds_if();

	encoder_speed_moving_average u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.samples     (samples_if),
		.speeds      (speeds_if),
		.scale_we    (scale_we),
		.scale_wdata (scale_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// speed model state
	logic [31:0] speed_scale_q16 = SCALE_RESET;
	logic [15:0] last_left = '0;
	logic [15:0] last_right = '0;
	int left_window [WINDOW_LENGTH] = '{default: 0};
	int right_window [WINDOW_LENGTH] = '{default: 0};
	longint left_total = 0;
	longint right_total = 0;
	int window_slot = 0;

	speed_result_t expected_speeds [$];
	speed_result_t oldest_speed;
	int mismatch_count = 0;
	int cycle_count = 0;
	logic sender_idle = 1'b1;
	logic receiver_idle = 1'b1;
	logic long_hold_pending = 1'b0;

	tick_row_t directed_ticks [25] = '{
		// first tick against a zero previous count
		'{1'b0, 32'd0, 16'h0000, 16'h0000, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 32'sd0}},
		// largest positive and negative deltas
		'{1'b0, 32'd0, 16'h7FFF, 16'h8000, 1'b1,
			'{32'sd32767, -32'sd32768, 32'sd3276, -32'sd3276}},
		'{1'b0, 32'd0, 16'hFFFF, 16'hFFFF, 1'b1,
			'{-32'sd32768, 32'sd32767, 32'sd0, 32'sd0}},
		'{1'b0, 32'd0, 16'hFFFF, 16'hFFFF, 1'b1, '{32'sd0, 32'sd0, 32'sd0, 32'sd0}},
		// counter wrap on the left, a step of minus one on the right
		'{1'b0, 32'd0, 16'h0000, 16'hFFFE, 1'b1, '{32'sd1, -32'sd1, 32'sd0, 32'sd0}},
		// largest scale with the largest deltas
		'{1'b1, 32'hFFFF_FFFF, 16'h7FFF, 16'h7FFE, 1'b1,
			'{32'sd2147418111, 32'sh8000_0000, 32'sd214741811, -32'sd214748365}},
		'{1'b0, 32'd0, 16'h7FFF, 16'h7FFE, 1'b1,
			'{32'sd0, 32'sd0, 32'sd214741811, -32'sd214748365}},
		'{1'b0, 32'd0, 16'h8000, 16'h7FFF, 1'b0, '0},
		'{1'b0, 32'd0, 16'h7FFF, 16'h8000, 1'b0, '0},
		// zero scale
		'{1'b1, 32'd0, 16'h1234, 16'hABCD, 1'b0, '0},
		'{1'b0, 32'd0, 16'h0000, 16'hFFFF, 1'b0, '0},
		// smallest scale, negative rounds toward minus infinity
		'{1'b1, 32'd1, 16'h0001, 16'h0000, 1'b0, '0},
		'{1'b0, 32'd0, 16'h0000, 16'hFFFF, 1'b0, '0},
		'{1'b1, 32'h0000_8000, 16'h0003, 16'h0002, 1'b0, '0},
		'{1'b0, 32'd0, 16'h0000, 16'hFFFF, 1'b0, '0},
		// unit scale, fill the whole window with one speed
		'{1'b1, SCALE_RESET, 16'h0064, 16'hFF9B, 1'b0, '0},
		'{1'b0, 32'd0, 16'h00C8, 16'hFF37, 1'b0, '0},
		'{1'b0, 32'd0, 16'h012C, 16'hFED3, 1'b0, '0},
		'{1'b0, 32'd0, 16'h0190, 16'hFE6F, 1'b0, '0},
		'{1'b0, 32'd0, 16'h01F4, 16'hFE0B, 1'b0, '0},
		'{1'b0, 32'd0, 16'h0258, 16'hFDA7, 1'b0, '0},
		'{1'b0, 32'd0, 16'h02BC, 16'hFD43, 1'b0, '0},
		'{1'b0, 32'd0, 16'h0320, 16'hFCDF, 1'b0, '0},
		'{1'b0, 32'd0, 16'h0384, 16'hFC7B, 1'b0, '0},
		'{1'b0, 32'd0, 16'h03E8, 16'hFC17, 1'b1,
			'{32'sd100, -32'sd100, 32'sd100, -32'sd100}}
	};

	function automatic logic signed [31:0] scaled_speed(input logic [15:0] now_count,
		input logic [15:0] last_count);
		logic signed [15:0] delta;
		longint delta_wide;
		longint scale_wide;
		longint whole;
		delta = now_count - last_count;
		delta_wide = delta;
		scale_wide = {32'd0, speed_scale_q16};
		whole = (delta_wide * scale_wide) >>> FRAC_W;
		if (whole > SPEED_MAX)
			return 32'sh7FFF_FFFF;
		if (whole < SPEED_MIN)
			return 32'sh8000_0000;
		return 32'(whole);
	endfunction

	function automatic speed_result_t next_speeds(input logic [15:0] left_now,
		input logic [15:0] right_now);
		speed_result_t res;
		res.left_speed = scaled_speed(left_now, last_left);
		res.right_speed = scaled_speed(right_now, last_right);
		last_left = left_now;
		last_right = right_now;
		left_total += longint'(res.left_speed) - longint'(left_window[window_slot]);
		right_total += longint'(res.right_speed) - longint'(right_window[window_slot]);
		left_window[window_slot] = res.left_speed;
		right_window[window_slot] = res.right_speed;
		window_slot = (window_slot + 1 == WINDOW_LENGTH) ? 0 : window_slot + 1;
		res.left_speed_average = 32'(left_total / WINDOW_LENGTH);
		res.right_speed_average = 32'(right_total / WINDOW_LENGTH);
		return res;
	endfunction

	function automatic logic [15:0] next_count(input logic [15:0] last_count);
		case ($urandom_range(0, 19))
			0: return last_count + 16'h7FFF;
			1: return last_count + 16'h8000;
			2: return last_count;
			3, 4, 5: return 16'($urandom);
			default: return last_count + 16'($urandom_range(0, 600)) - 16'd300;
		endcase
	endfunction

	task automatic report_mismatch(input string field, input logic signed [31:0] got,
		input logic signed [31:0] want);
		if (mismatch_count < PRINT_LIMIT)
			$display("mismatch %s: got %0d expected %0d", field, got, want);
		mismatch_count++;
	endtask

	task automatic send_tick(input logic [15:0] left_now, input logic [15:0] right_now,
		input logic typed, input speed_result_t typed_result);
		speed_result_t predicted;
		if (sender_idle && $urandom_range(0, 4) == 0) begin
			samples_if.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		samples_if.valid <= 1'b1;
		samples_if.left_count <= left_now;
		samples_if.right_count <= right_now;
		do @(posedge clk); while (!samples_if.ready);
		predicted = next_speeds(left_now, right_now);
		expected_speeds.push_back(typed ? typed_result : predicted);
	endtask

	task automatic drain_speeds();
		samples_if.valid <= 1'b0;
		while (expected_speeds.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_scale(input logic [31:0] scale);
		drain_speeds();
		scale_we <= 1'b1;
		scale_wdata <= scale;
		@(posedge clk);
		scale_we <= 1'b0;
		speed_scale_q16 = scale;
	endtask

	// output side: ready bursts and the long hold
	initial begin
		speeds_if.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (long_hold_pending) begin
				long_hold_pending = 1'b0;
				speeds_if.ready <= 1'b0;
				repeat (LONG_HOLD_CYCLES) @(posedge clk);
			end else if (receiver_idle && $urandom_range(0, 4) == 0) begin
				speeds_if.ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				speeds_if.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// check every speed transaction against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && speeds_if.valid && speeds_if.ready) begin
			if (expected_speeds.size() == 0) begin
				report_mismatch("unexpected transaction", speeds_if.left_speed, 32'sd0);
			end else begin
				oldest_speed = expected_speeds.pop_front();
				if (speeds_if.left_speed !== oldest_speed.left_speed)
					report_mismatch("left_speed", speeds_if.left_speed,
						oldest_speed.left_speed);
				if (speeds_if.right_speed !== oldest_speed.right_speed)
					report_mismatch("right_speed", speeds_if.right_speed,
						oldest_speed.right_speed);
				if (speeds_if.left_speed_average !== oldest_speed.left_speed_average)
					report_mismatch("left_speed_average", speeds_if.left_speed_average,
						oldest_speed.left_speed_average);
				if (speeds_if.right_speed_average !== oldest_speed.right_speed_average)
					report_mismatch("right_speed_average", speeds_if.right_speed_average,
						oldest_speed.right_speed_average);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		logic [31:0] phase_scale;
		samples_if.valid = 1'b0;
		samples_if.left_count = '0;
		samples_if.right_count = '0;
		scale_we = 1'b0;
		scale_wdata = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_ticks[i]) begin
			if (directed_ticks[i].set_scale)
				write_scale(directed_ticks[i].scale);
			send_tick(directed_ticks[i].left_count, directed_ticks[i].right_count,
				directed_ticks[i].typed, directed_ticks[i].result);
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: phase_scale = $urandom;
				1: phase_scale = 32'hFFFF_FFFF;
				2: phase_scale = $urandom_range(0, 32'h0002_0000);
				3: phase_scale = 32'd0;
				4: phase_scale = $urandom;
				5: phase_scale = 32'd1;
				6: phase_scale = $urandom >> $urandom_range(0, 31);
				default: phase_scale = SCALE_RESET;
			endcase
			sender_idle = (phase != 0) && (phase != PHASES - 1);
			receiver_idle = sender_idle;
			write_scale(phase_scale);
			// output stalls long enough to back up the pipeline
			if (phase == 2)
				long_hold_pending = 1'b1;
			for (int n = 0; n < TICKS_PER_PHASE; n++) begin
				// pause input until every pending transaction is out
				if (phase == 4 && n == TICKS_PER_PHASE / 2)
					drain_speeds();
				send_tick(next_count(last_left), next_count(last_right), 1'b0, '0);
			end
		end

		drain_speeds();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/esma_pkg.sv
rtl/esma_if.sv
rtl/esma_wheel.sv
rtl/encoder_speed_moving_average.sv
tb/encoder_speed_moving_average_tb.sv
